// ----- src/assert_macros.svh -----
// Assertion macros used by the scheduler checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define SCPS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// Clocked check that also runs through reset.
`define SCPS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ----- src/scps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scps_pkg;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_POLL  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_ABORT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    HEALTH_OK      = 2'd0,
    HEALTH_BUS     = 2'd1,
    HEALTH_TIMEOUT = 2'd2
  } health_t;

  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE             = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONVERSION_TIMEOUT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SAMPLE_PERIOD_RESET      = 20'd10000;
  localparam logic [CFG_DATA_W-1:0] CONVERSION_TIMEOUT_RESET = 20'd20000;

  typedef struct packed {
    logic [63:0] now_us;
    logic        start_write_ok;
    logic        status_read_ok;
    logic [7:0]  status_byte;
    logic        sample_read_ok;
    logic [7:0]  sample_status_byte;
  } in_word_t;

  typedef struct packed {
    action_t action;
    health_t sensor_status;
    logic    converting;
    logic    sample_accepted;
  } out_word_t;

  typedef struct packed {
    logic                  enable;
    logic [CFG_DATA_W-1:0] sample_period;
    logic [CFG_DATA_W-1:0] conversion_timeout;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [63:0] start_time;
    logic [63:0] next_sample_time;
    logic [63:0] next_check_time;
    health_t     health;
  } sched_state_t;

endpackage

`default_nettype wire

// ----- src/scps_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scps_step #(
  parameter int STATUS_POLL_US = 1000
) (
  input  scps_pkg::cfg_t         cfg,
  input  scps_pkg::sched_state_t state,
  input  scps_pkg::in_word_t     word,
  output scps_pkg::sched_state_t state_next,
  output scps_pkg::out_word_t    result
);
  import scps_pkg::*;

  localparam logic [63:0] POLL_US = 64'(STATUS_POLL_US);

  logic [63:0] check_next;
  logic [63:0] resched_now;
  logic [63:0] resched_start;
  logic [63:0] elapsed;
  logic        sample_due;
  logic        check_due;
  logic        timed_out;

  assign check_next    = word.now_us + POLL_US;
  assign resched_now   = word.now_us + 64'(cfg.sample_period);
  assign resched_start = state.start_time + 64'(cfg.sample_period);
  assign elapsed       = word.now_us - state.start_time;
  assign sample_due    = word.now_us >= state.next_sample_time;
  assign check_due     = word.now_us >= state.next_check_time;
  assign timed_out     = elapsed > 64'(cfg.conversion_timeout);

  action_t action;
  logic    accepted;

  always_comb begin
    state_next = state;
    action     = ACT_NONE;
    accepted   = 1'b0;
    if (cfg.enable) begin
      if (!state.active) begin
        if (sample_due) begin
          action = ACT_START;
          if (word.start_write_ok) begin
            state_next.active          = 1'b1;
            state_next.start_time      = word.now_us;
            state_next.next_check_time = check_next;
          end else begin
            state_next.health = HEALTH_BUS;
          end
        end
      end else if (check_due) begin
        state_next.next_check_time = check_next;
        action = ACT_POLL;
        priority if (!word.status_read_ok) begin
          state_next.active           = 1'b0;
          state_next.health           = HEALTH_BUS;
          state_next.next_sample_time = resched_now;
        end else if (word.status_byte[0]) begin
          action                      = ACT_READ;
          state_next.active           = 1'b0;
          state_next.next_sample_time = resched_start;
          if (word.sample_read_ok && word.sample_status_byte[0]) begin
            state_next.health = HEALTH_OK;
            accepted          = 1'b1;
          end else begin
            state_next.health = HEALTH_BUS;
          end
        end else if (timed_out) begin
          action                      = ACT_ABORT;
          state_next.active           = 1'b0;
          state_next.health           = HEALTH_TIMEOUT;
          state_next.next_sample_time = resched_now;
        end else begin
          state_next.active = state.active;
        end
      end
    end
  end

  always_comb begin
    result.action          = action;
    result.sensor_status   = state_next.health;
    result.converting      = state_next.active;
    result.sample_accepted = accepted;
  end

endmodule

`default_nettype wire

// ----- src/sensor_conversion_poll_scheduler.sv -----
// Conversion poll scheduler: takes one poll tick word per clock while the output is not
// stalled and returns one result word per tick, through an input register, then a result
// register. Throughput is one tick per cycle without output stalls; the only loop is the
// scheduler state (active flag, start, next sample and next check times, health), updated
// once per tick by one pass of 64-bit compares and adds. Configuration writes take effect
// on the next tick that reaches the result stage. Out-of-range register indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none

module sensor_conversion_poll_scheduler #(
  parameter int STATUS_POLL_US = 1000
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  scps_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output scps_pkg::out_word_t                 out_data,
  input  wire                                 cfg_write,
  input  wire [scps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [scps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import scps_pkg::*;

  cfg_t         cfg;
  sched_state_t state;
  sched_state_t state_next;
  in_word_t     in_q;
  logic         in_q_valid;
  out_word_t    result;
  logic         advance;
  logic         in_take;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.sample_period      <= SAMPLE_PERIOD_RESET;
      cfg.conversion_timeout <= CONVERSION_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE:             cfg.enable             <= cfg_data[0];
        CFG_SAMPLE_PERIOD:      cfg.sample_period      <= cfg_data;
        CFG_CONVERSION_TIMEOUT: cfg.conversion_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the tick word until the result stage frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_data;
    end
  end

  scps_step #(
    .STATUS_POLL_US(STATUS_POLL_US)
  ) u_step (
    .cfg       (cfg),
    .state     (state),
    .word      (in_q),
    .state_next(state_next),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_q_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_valid && advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- src/scps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module scps_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_stall,
  input scps_pkg::out_word_t out_data
);
  import scps_pkg::*;

  `SCPS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result word after reset")

  `SCPS_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled word changed")

  `SCPS_ASSERT(a_accept_read,
    out_valid && out_data.sample_accepted |->
      out_data.action == ACT_READ && out_data.sensor_status == HEALTH_OK,
    "sample taken without healthy read")

  `SCPS_ASSERT(a_end_idle,
    out_valid && (out_data.action == ACT_READ || out_data.action == ACT_ABORT) |->
      !out_data.converting,
    "conversion still running after read or abort")

  `SCPS_ASSERT(a_abort_timeout,
    out_valid && out_data.action == ACT_ABORT |-> out_data.sensor_status == HEALTH_TIMEOUT,
    "abort without timeout status")

endmodule

bind sensor_conversion_poll_scheduler scps_checker u_scps_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// ----- tb/poll_schedule_checker.sv -----
`timescale 1ns / 1ps

module poll_schedule_checker #(
  parameter int STATUS_POLL_US = 1000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  scps_pkg::in_word_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  scps_pkg::out_word_t                 out_data,
  input  logic                                cfg_write,
  input  logic [scps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  failures,
  output int                                  waiting,
  output int                                  results_seen,
  output int                                  samples_taken,
  output int                                  aborts_seen
);
  import scps_pkg::*;

  localparam int PRINT_CAP = 40;

  logic                  sched_enable;
  logic [CFG_DATA_W-1:0] sched_period;
  logic [CFG_DATA_W-1:0] sched_timeout;

  logic        conv_active;
  logic [63:0] conv_start_us;
  logic [63:0] next_start_us;
  logic [63:0] next_poll_us;
  health_t     cur_health;

  out_word_t expected_words[$];

  function automatic out_word_t predict_tick(input in_word_t w);
    out_word_t r;
    action_t   act;
    logic      taken;
    act = ACT_NONE;
    taken = 1'b0;
    if (sched_enable) begin
      if (!conv_active) begin
        if (w.now_us >= next_start_us) begin
          act = ACT_START;
          if (w.start_write_ok) begin
            conv_active = 1'b1;
            conv_start_us = w.now_us;
            next_poll_us = w.now_us + 64'(STATUS_POLL_US);
          end else begin
            cur_health = HEALTH_BUS;
          end
        end
      end else if (w.now_us >= next_poll_us) begin
        next_poll_us = w.now_us + 64'(STATUS_POLL_US);
        act = ACT_POLL;
        if (!w.status_read_ok) begin
          conv_active = 1'b0;
          cur_health = HEALTH_BUS;
          next_start_us = w.now_us + 64'(sched_period);
        end else if (w.status_byte[0]) begin
          act = ACT_READ;
          conv_active = 1'b0;
          if (w.sample_read_ok && w.sample_status_byte[0]) begin
            cur_health = HEALTH_OK;
            taken = 1'b1;
          end else begin
            cur_health = HEALTH_BUS;
          end
          next_start_us = conv_start_us + 64'(sched_period);
        end else if ((w.now_us - conv_start_us) > 64'(sched_timeout)) begin
          act = ACT_ABORT;
          conv_active = 1'b0;
          cur_health = HEALTH_TIMEOUT;
          next_start_us = w.now_us + 64'(sched_period);
        end
      end
    end
    r.action = act;
    r.sensor_status = cur_health;
    r.converting = conv_active;
    r.sample_accepted = taken;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    failures++;
    if (failures <= PRINT_CAP)
      $display("%0t: result %0d: %s is %0d, predicted %0d", $time, results_seen, what, got,
               want);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      sched_enable = 1'b0;
      sched_period = SAMPLE_PERIOD_RESET;
      sched_timeout = CONVERSION_TIMEOUT_RESET;
      conv_active = 1'b0;
      conv_start_us = '0;
      next_start_us = '0;
      next_poll_us = '0;
      cur_health = HEALTH_OK;
      expected_words.delete();
      waiting = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ENABLE:             sched_enable = cfg_data[0];
          CFG_SAMPLE_PERIOD:      sched_period = cfg_data;
          CFG_CONVERSION_TIMEOUT: sched_timeout = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(predict_tick(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no tick outstanding", 8'(out_data), 8'd0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.action !== want.action)
            report_mismatch("action", 8'(out_data.action), 8'(want.action));
          if (out_data.sensor_status !== want.sensor_status)
            report_mismatch("sensor_status", 8'(out_data.sensor_status),
                            8'(want.sensor_status));
          if (out_data.converting !== want.converting)
            report_mismatch("converting", 8'(out_data.converting), 8'(want.converting));
          if (out_data.sample_accepted !== want.sample_accepted)
            report_mismatch("sample_accepted", 8'(out_data.sample_accepted),
                            8'(want.sample_accepted));
          if (want.sample_accepted) samples_taken++;
          if (want.action == ACT_ABORT) aborts_seen++;
        end
        results_seen++;
      end
      waiting = expected_words.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import scps_pkg::*;

  localparam int POLL_US = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 60;
  localparam int PHASE_TICKS = 75;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int failures;
  int waiting;
  int results_seen;
  int samples_taken;
  int aborts_seen;

  int          cycle_count = 0;
  int          ticks_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  logic [63:0] clock_us = '0;

  sensor_conversion_poll_scheduler #(
    .STATUS_POLL_US(POLL_US)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  poll_schedule_checker #(
    .STATUS_POLL_US(POLL_US)
  ) schedule_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .failures(failures),
    .waiting(waiting),
    .results_seen(results_seen),
    .samples_taken(samples_taken),
    .aborts_seen(aborts_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, waiting);
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold whenever one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input in_word_t w);
    int unsigned gap;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_word_t make_word(input logic [63:0] now, input logic start_ok,
                                         input logic status_ok, input logic [7:0] status_b,
                                         input logic sample_ok, input logic [7:0] sample_b);
    in_word_t w;
    w.now_us = now;
    w.start_write_ok = start_ok;
    w.status_read_ok = status_ok;
    w.status_byte = status_b;
    w.sample_read_ok = sample_ok;
    w.sample_status_byte = sample_b;
    return w;
  endfunction

  function automatic in_word_t random_word(input logic [63:0] now);
    in_word_t w;
    w.now_us = now;
    w.start_write_ok = ($urandom_range(99) < 90);
    w.status_read_ok = ($urandom_range(99) < 92);
    w.status_byte = 8'($urandom);
    w.status_byte[0] = ($urandom_range(99) < 35);
    w.sample_read_ok = ($urandom_range(99) < 90);
    w.sample_status_byte = 8'($urandom);
    w.sample_status_byte[0] = ($urandom_range(99) < 90);
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_interval();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 20'd1000000;
      2:       return 20'($urandom_range(1, 3000));
      default: return 20'($urandom_range(1000, 12000));
    endcase
  endfunction

  // force the block idle, then start the schedule over from base
  task automatic resync(input logic [63:0] base);
    send_tick(make_word('1, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00));
    send_tick(make_word('1, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00));
    send_tick(make_word(base, 1'b1, 1'b0, 8'h01, 1'b1, 8'h01));
    clock_us = base;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] period,
                           input logic [CFG_DATA_W-1:0] timeout_us);
    logic [CFG_DATA_W-1:0] en_word;
    wait_drained();
    write_reg(CFG_SAMPLE_PERIOD, period);
    write_reg(CFG_CONVERSION_TIMEOUT, timeout_us);
    en_word = 20'($urandom);
    en_word[0] = 1'b0;
    write_reg(CFG_ENABLE, en_word);
    repeat (4) send_tick(random_word(clock_us + $urandom_range(5000)));
    wait_drained();
    en_word = 20'($urandom);
    en_word[0] = 1'b1;
    write_reg(CFG_ENABLE, en_word);
    if ($urandom_range(1) != 0) write_reg(CFG_UNUSED_INDEX, 20'($urandom));
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned step_max);
    in_word_t w;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) begin
        w = random_word(clock_us - $urandom_range(1, 3000));
      end else begin
        clock_us = clock_us + $urandom_range(step_max);
        w = random_word(clock_us);
      end
      send_tick(w);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] period;
    logic [CFG_DATA_W-1:0] timeout_us;
    logic [63:0]           base;
    int unsigned           step_max;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 11;
    recv_idle_pct <= 64;

    // disabled after reset: ignored
    send_tick(make_word('1, 1'b1, 1'b1, 8'hFF, 1'b1, 8'hFF));
    send_tick(make_word('0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00));
    wait_drained();
    write_reg(CFG_UNUSED_INDEX, '1);
    write_reg(CFG_SAMPLE_PERIOD, 20'd2000);
    write_reg(CFG_CONVERSION_TIMEOUT, 20'd3000);
    write_reg(CFG_ENABLE, '1);

    send_tick(make_word(64'd0, 1'b0, 1'b1, 8'h01, 1'b1, 8'h01));
    send_tick(make_word(64'd0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00));
    send_tick(make_word(64'd500, 1'b0, 1'b0, 8'hFF, 1'b0, 8'h00));
    send_tick(make_word(64'd1000, 1'b0, 1'b1, 8'hFE, 1'b0, 8'h00));
    send_tick(make_word(64'd2000, 1'b0, 1'b1, 8'h01, 1'b1, 8'hFF));
    send_tick(make_word(64'd2000, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00));
    send_tick(make_word(64'd3000, 1'b1, 1'b0, 8'h01, 1'b1, 8'h01));
    send_tick(make_word(64'd5000, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word(64'd9000, 1'b1, 1'b1, 8'h80, 1'b1, 8'h01));
    send_tick(make_word(64'd11000, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word(64'd12000, 1'b1, 1'b1, 8'h01, 1'b0, 8'h01));
    send_tick(make_word(64'd13000, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word(64'd14000, 1'b1, 1'b1, 8'h01, 1'b1, 8'hFE));
    send_tick(make_word(64'd15000, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word(64'd16000, 1'b1, 1'b1, 8'h01, 1'b1, 8'h01));
    // start just below the wrap, then a time far before the start
    send_tick(make_word(64'hFFFF_FFFF_FFFF_FF9C, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word(64'h8000_0000_0000_0000, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word('1, 1'b1, 1'b1, 8'h00, 1'b1, 8'h01));
    send_tick(make_word('1, 1'b1, 1'b1, 8'hFF, 1'b1, 8'hFF));

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct <= 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct <= 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int ph = 0; ph < 3; ph++) begin
        if (mode == 0 && ph == 0) begin
          period = '0;
          timeout_us = '0;
        end else if (mode == 1 && ph == 0) begin
          period = 20'd1000000;
          timeout_us = 20'd1000000;
        end else if (mode == 2 && ph == 0) begin
          period = '1;
          timeout_us = '1;
        end else begin
          period = pick_interval();
          timeout_us = pick_interval();
        end
        step_max = ((period > timeout_us) ? period : timeout_us) / 6 + 1500;
        configure(period, timeout_us);
        base = {$urandom, $urandom};
        if (base < 64'd1000) base = 64'd1000;
        resync(base);
        if (mode == 2 && ph == 2) begin
          // hold the output for a long stretch while ticks keep coming
          holds_asked <= holds_asked + 1;
          run_ticks(PHASE_TICKS / 2, step_max);
          wait_drained();
          run_ticks(PHASE_TICKS - PHASE_TICKS / 2, step_max);
        end else begin
          run_ticks(PHASE_TICKS, step_max);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run: %0d ticks sent, %0d result words checked, %0d samples taken, %0d aborts",
             ticks_sent, results_seen, samples_taken, aborts_seen);
    $display("run: periods and timeouts from 0 to 20'hFFFFF, time wrap, long output hold");
    if (failures == 0 && waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/scps_pkg.sv
src/scps_step.sv
src/sensor_conversion_poll_scheduler.sv
src/scps_checker.sv
tb/poll_schedule_checker.sv
tb/testbench.sv
